// ===== sv/rnt_pkg.sv =====
package rnt_pkg;

  // Table geometry.
  localparam int ENTRIES = 5;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths.
  localparam int OP_W   = 2;
  localparam int KEY_W  = 64;
  localparam int RSSI_W = 8;
  localparam int SLOT_W = 3;

  // Strength floor in dBm; also the strength of a freshly taken entry.
  localparam logic signed [RSSI_W-1:0] FLOOR_DBM = -8'sd100;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_SCAN_START = 2'd0;
  localparam logic [OP_W-1:0] OP_REPORT     = 2'd1;
  localparam logic [OP_W-1:0] OP_SCAN_END   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [KEY_W-1:0]         ap_key;
    logic signed [RSSI_W-1:0] ap_rssi;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic signed [RSSI_W-1:0] rssi_average;
    logic                     is_new;
  } rsp_t;

endpackage

// ===== sv/rnt_third.sv =====
module rnt_third import rnt_pkg::*; (
  input  logic signed [RSSI_W-1:0] str_i,
  input  logic signed [RSSI_W-1:0] addend_i,
  output logic signed [RSSI_W-1:0] avg_o
);

  // Computes round((2*str + addend) / 3) with ties impossible.
  // The magnitude plus one is divided by 3 through a multiply by 171/512,
  // which is exact for every magnitude this unit can see (at most 385).
  logic signed [RSSI_W+1:0] sum;
  logic                     neg;
  logic [RSSI_W:0]          mag;
  logic [RSSI_W:0]          mag_p1;
  logic [2*RSSI_W:0]        prod;
  logic [RSSI_W-1:0]        quo;

  always_comb begin
    sum    = ({str_i[RSSI_W-1], str_i, 1'b0})
           + {{2{addend_i[RSSI_W-1]}}, addend_i};
    neg    = sum[RSSI_W+1];
    mag    = neg ? (RSSI_W+1)'(-sum) : sum[RSSI_W:0];
    mag_p1 = mag + (RSSI_W+1)'(1);
    prod   = (2*RSSI_W+1)'(mag_p1) * (2*RSSI_W+1)'(171);
    quo    = prod[2*RSSI_W:RSSI_W+1];
    avg_o  = neg ? $signed(-quo) : $signed(quo);
  end

endmodule

// ===== sv/rssi_neighbor_table.sv =====
// Channel | Direction | Handshake               | Payload
// in      | request   | in_valid_i / in_stall_o | in_req_i  (opcode, ap_key, ap_rssi)
// out     | result    | out_valid_o / out_stall_i | out_rsp_o (slot, rssi_average, is_new)
//
// A sequencer handles one request at a time, one entry per cycle, through one shared
// divide-by-three unit. After acceptance a scan start or end walks every entry, and a
// report searches up to a match or the last entry and then takes an update step;
// unused opcodes and zero keys end at acceptance. Reset empties the table at once:
// keys zero, strengths -100, flags clear. The update step holds while the output
// register is full and stalled; the input stalls meanwhile.
module rssi_neighbor_table import rnt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_DECAY  = 3'd2;
  localparam logic [2:0] ST_SEARCH = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [2:0]               state_q, state_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  req_t                     req_q, req_d;
  logic                     hit_q, hit_d;
  logic [IDX_W-1:0]         weak_q, weak_d;
  logic signed [RSSI_W-1:0] weak_str_q, weak_str_d;
  logic                     out_valid_q, out_valid_d;
  rsp_t                     out_rsp_q, out_rsp_d;

  // The table itself.
  logic [KEY_W-1:0]         key_q [ENTRIES];
  logic [KEY_W-1:0]         key_d [ENTRIES];
  logic signed [RSSI_W-1:0] str_q [ENTRIES];
  logic signed [RSSI_W-1:0] str_d [ENTRIES];
  logic [ENTRIES-1:0]       act_q, act_d;

  logic signed [RSSI_W-1:0] cur_str;
  logic [KEY_W-1:0]         cur_key;
  logic signed [RSSI_W-1:0] addend;
  logic signed [RSSI_W-1:0] avg;
  logic                     last;
  logic                     weaker;

  // The shared averaging unit always sees the entry under the walk index.
  // During decay the new sample is the floor, otherwise the reported strength.
  rnt_third u_third (
    .str_i    (cur_str),
    .addend_i (addend),
    .avg_o    (avg)
  );

  always_comb begin
    cur_str = str_q[idx_q];
    cur_key = key_q[idx_q];
    addend  = (state_q == ST_DECAY) ? FLOOR_DBM : req_q.ap_rssi;
    last    = (idx_q == LAST_IDX);
    weaker  = (cur_str < weak_str_q);

    state_d     = state_q;
    idx_d       = idx_q;
    req_d       = req_q;
    hit_d       = hit_q;
    weak_d      = weak_q;
    weak_str_d  = weak_str_q;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    key_d       = key_q;
    str_d       = str_q;
    act_d       = act_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_req_i;
          idx_d      = '0;
          weak_d     = '0;
          weak_str_d = 8'sd127;
          if (in_req_i.opcode == OP_SCAN_START) begin
            state_d = ST_CLEAR;
          end else if (in_req_i.opcode == OP_SCAN_END) begin
            state_d = ST_DECAY;
          end else if (in_req_i.opcode == OP_REPORT && in_req_i.ap_key != '0) begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_CLEAR: begin
        act_d[idx_q] = 1'b0;
        if (last) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_DECAY: begin
        // Only inactive entries strictly above the floor fade toward it.
        if (!act_q[idx_q] && cur_str > FLOOR_DBM) begin
          str_d[idx_q] = avg;
        end
        if (last) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      ST_SEARCH: begin
        if (cur_key == req_q.ap_key) begin
          hit_d   = 1'b1;
          state_d = ST_UPDATE;
        end else begin
          // Strict compare keeps the first minimum.
          if (weaker) begin
            weak_d     = idx_q;
            weak_str_d = cur_str;
          end
          if (last) begin
            hit_d   = 1'b0;
            idx_d   = weaker ? idx_q : weak_q;
            state_d = ST_UPDATE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end
      ST_UPDATE: begin
        if (!out_valid_q || !out_stall_i) begin
          act_d[idx_q]     = 1'b1;
          out_valid_d      = 1'b1;
          out_rsp_d.slot   = SLOT_W'(idx_q);
          out_rsp_d.is_new = !hit_q;
          if (hit_q) begin
            str_d[idx_q]           = avg;
            out_rsp_d.rssi_average = avg;
          end else begin
            key_d[idx_q]           = req_q.ap_key;
            str_d[idx_q]           = FLOOR_DBM;
            out_rsp_d.rssi_average = FLOOR_DBM;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      weak_q      <= '0;
      out_valid_q <= 1'b0;
      act_q       <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i] <= '0;
        str_q[i] <= FLOOR_DBM;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      weak_q      <= weak_d;
      out_valid_q <= out_valid_d;
      act_q       <= act_d;
      key_q       <= key_d;
      str_q       <= str_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    weak_str_q <= weak_str_d;
    out_rsp_q  <= out_rsp_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ===== sv/rnt_checker.sv =====
module rnt_checker import rnt_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  // A newly taken entry always starts at the floor.
  a_new_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.is_new |-> out_rsp_o.rssi_average == FLOOR_DBM)
    else $error("new entry strength is not the floor");

  // Slots name real entries.
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ENTRIES > 8) || (out_rsp_o.slot <= SLOT_W'(ENTRIES - 1)))
    else $error("slot out of range");

  // A result only appears after the block was busy with a request.
  a_busy_before_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in progress");

endmodule

bind rssi_neighbor_table rnt_checker u_checker (.*);

// ===== sim/tb_rssi_neighbor_table.sv =====
`timescale 1ns / 100ps

module tb_rssi_neighbor_table;
  import rnt_pkg::*;

  // The package names only the three opcodes in use; the fourth is ignored by
  // the block and is sent here as noise.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The strength floor, widened so that the table arithmetic runs in int.
  localparam int FLOOR = FLOOR_DBM;

  // Keys reported within the random scans are mostly drawn from a small pool,
  // larger than the table, so that matches and evictions both happen often.
  localparam int KEY_POOL = 8;

  // The single long receiver hold-off and the settling time at the end.
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4 * ENTRIES + 10;

  // This limit leaves a wide margin on top of the slowest correct run.
  localparam int TIMEOUT_NS = 2_000_000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_rsp_o;

  rssi_neighbor_table u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Requests waiting to be offered, and the results that the requests already
  // accepted must still produce, oldest first.
  req_t pending_q[$];
  rsp_t expected_q[$];

  // Idling percentages of the current phase, and the long hold-off switch.
  int  sender_idle_pct = 0;
  int  stall_pct       = 0;
  bit  hold_on         = 1'b0;
  int  hold_count      = 0;

  bit  req_taken   = 1'b0;
  int  error_count = 0;
  int  n_requests  = 0;
  int  n_results   = 0;
  int  n_new       = 0;
  int  n_matched   = 0;
  int  n_blocked   = 0;
  int  phase_items = 0;

  logic [KEY_W-1:0] key_pool [KEY_POOL];

  // Our own copy of the neighbor table, updated as each request is accepted.
  logic [KEY_W-1:0] tbl_key      [ENTRIES];
  int               tbl_strength [ENTRIES];
  bit               tbl_active   [ENTRIES];

  initial begin
    foreach (tbl_key[i]) begin
      tbl_key[i]      = '0;
      tbl_strength[i] = FLOOR;
      tbl_active[i]   = 1'b0;
    end
  end

  // Division by three, rounded to the nearest integer. A remainder of one
  // third can never be a tie, so rounding half away from zero is enough.
  function automatic int third_nearest(input int n);
    if (n >= 0) begin
      return (n + 1) / 3;
    end
    return -((-n + 1) / 3);
  endfunction

  // Applies one accepted request to the table copy. Returns 1 when the request
  // produces a result, and fills in that result.
  function automatic bit update_table(input req_t r, output rsp_t rsp);
    int hit;
    int weakest;
    int slot;
    rsp = '0;
    unique case (r.opcode)
      OP_SCAN_START: begin
        foreach (tbl_active[i]) tbl_active[i] = 1'b0;
        return 1'b0;
      end
      OP_SCAN_END: begin
        // Only neighbors not heard in this scan fade, and never below the
        // floor. Entries already under the floor are left as they are.
        foreach (tbl_strength[i]) begin
          if (!tbl_active[i] && tbl_strength[i] > FLOOR) begin
            tbl_strength[i] = third_nearest(2 * tbl_strength[i] + FLOOR);
          end
        end
        return 1'b0;
      end
      OP_REPORT: begin
        // A zero key marks an empty entry and is never stored.
        if (r.ap_key == '0) begin
          return 1'b0;
        end
        hit = -1;
        weakest = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_key[i] == r.ap_key) begin
            hit = i;
            break;
          end
          if (tbl_strength[i] < tbl_strength[weakest]) begin
            weakest = i;
          end
        end
        if (hit >= 0) begin
          slot = hit;
          tbl_strength[slot] = third_nearest(2 * tbl_strength[slot] + int'(r.ap_rssi));
          rsp.is_new = 1'b0;
        end else begin
          // No match: the first of the weakest entries is replaced, whether
          // it was heard in this scan or not.
          slot = weakest;
          tbl_key[slot] = r.ap_key;
          tbl_strength[slot] = FLOOR;
          rsp.is_new = 1'b1;
        end
        tbl_active[slot] = 1'b1;
        rsp.slot = slot[SLOT_W-1:0];
        rsp.rssi_average = tbl_strength[slot][RSSI_W-1:0];
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Request driver. A new request is offered only once the previous one has
  // been taken, so valid never reacts to the stall and a stalled request holds
  // still. Between requests the sender may idle at random.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_req_i   <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result stall. The long hold-off runs once, counted here, and otherwise the
  // receiver stalls at random with the phase's percentage.
  always @(negedge clk_i) begin
    if (hold_on && hold_count < HOLD_CYCLES) begin
      out_stall_i <= 1'b1;
      hold_count  <= hold_count + 1;
    end else begin
      out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor. Results are checked against the oldest expectation before the
  // request taken at the same edge adds its own, which cannot be due yet.
  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    rsp_t pred;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        got = out_rsp_o;
        n_results++;
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: slot %0d average %0d is_new %0b",
                 got.slot, got.rssi_average, got.is_new);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
            error_count++;
          end
          if (got.rssi_average !== want.rssi_average) begin
            $error("rssi_average mismatch: expected %0d, actual %0d",
                   want.rssi_average, got.rssi_average);
            error_count++;
          end
          if (got.is_new !== want.is_new) begin
            $error("is_new mismatch: expected %0b, actual %0b", want.is_new, got.is_new);
            error_count++;
          end
        end
      end
      req_taken <= in_valid_i && in_stall_o === 1'b0;
      if (in_valid_i && in_stall_o === 1'b0) begin
        n_requests++;
        if (update_table(in_req_i, pred)) begin
          expected_q.push_back(pred);
          if (pred.is_new) n_new++;
          else n_matched++;
        end
      end
      if (in_valid_i && in_stall_o === 1'b1) n_blocked++;
    end
  end

  task automatic push_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                          input logic signed [RSSI_W-1:0] rssi);
    req_t r;
    r.opcode  = op;
    r.ap_key  = key;
    r.ap_rssi = rssi;
    pending_q.push_back(r);
    // Unused opcodes and zero-key reports are ignored by the block and do
    // not count toward a phase's length.
    if (op == OP_SCAN_START || op == OP_SCAN_END || (op == OP_REPORT && key != '0)) begin
      phase_items++;
    end
  endtask

  function automatic logic [KEY_W-1:0] any_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [RSSI_W-1:0] any_rssi();
    return RSSI_W'($urandom_range(255));
  endfunction

  // One scan as the radio would see it: a start, a handful of reports mostly
  // from known neighbors, and an end. Now and then the start or end is left
  // out, or a report is replaced by noise.
  task automatic push_scan();
    int n_rep;
    int pick;
    if ($urandom_range(9) != 0) push_req(OP_SCAN_START, any_key(), any_rssi());
    n_rep = $urandom_range(8, 1);
    repeat (n_rep) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        push_req(OP_REPORT, key_pool[$urandom_range(KEY_POOL - 1)], any_rssi());
      end else if (pick < 88) begin
        push_req(OP_REPORT, any_key(), any_rssi());
      end else if (pick < 94) begin
        push_req(OP_REPORT, '0, any_rssi());
      end else begin
        push_req(OP_UNUSED, any_key(), any_rssi());
      end
    end
    if ($urandom_range(9) != 0) push_req(OP_SCAN_END, any_key(), any_rssi());
    // A neighbor occasionally disappears and a new one shows up.
    if ($urandom_range(3) == 0) key_pool[$urandom_range(KEY_POOL - 1)] = any_key();
  endtask

  // Waits until every request has been taken and every result has arrived.
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall, input int n_items);
    sender_idle_pct = idle_pct;
    stall_pct = stall;
    phase_items = 0;
    while (phase_items < n_items) push_scan();
    wait_drained();
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = any_key();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests: the first reports take empty entries, then matches
    // with strengths at both ends of the range push an average below the
    // floor. A report at -97 on a fresh entry lands on -99, which a scan
    // end must leave in place. New keys then evict the weakest entry while an
    // empty one remains, and zero keys, the unused opcode and back-to-back
    // scan edges are sent as well.
    push_req(OP_REPORT, 64'h0123_4567_89AB_CDEF, 8'sd127);
    push_req(OP_REPORT, 64'h0123_4567_89AB_CDEF, 8'sd127);
    push_req(OP_REPORT, 64'h0123_4567_89AB_CDEF, -8'sd128);
    push_req(OP_REPORT, '1, -8'sd128);
    push_req(OP_REPORT, '1, -8'sd128);
    push_req(OP_REPORT, '0, 8'sd5);
    push_req(OP_UNUSED, 64'h0123_4567_89AB_CDEF, 8'sd0);
    push_req(OP_REPORT, 64'h1, -8'sd97);
    push_req(OP_REPORT, 64'h1, -8'sd97);
    push_req(OP_REPORT, 64'h8000_0000_0000_0000, 8'sd0);
    push_req(OP_REPORT, 64'hFEDC_BA98_7654_3210, -8'sd1);
    push_req(OP_REPORT, 64'hFEDC_BA98_7654_3210, 8'sd127);
    push_req(OP_REPORT, 64'h5555_5555_5555_5555, 8'sd1);
    push_req(OP_SCAN_START, '0, 8'sd0);
    push_req(OP_REPORT, 64'h0123_4567_89AB_CDEF, -8'sd40);
    push_req(OP_SCAN_END, '0, 8'sd0);
    push_req(OP_SCAN_END, '1, -8'sd1);
    push_req(OP_SCAN_START, '1, -8'sd128);
    push_req(OP_SCAN_END, 64'hFEDC_BA98_7654_3210, 8'sd127);
    push_req(OP_REPORT, 64'h8000_0000_0000_0000, 8'sd127);
    push_req(OP_REPORT, 64'hAAAA_AAAA_AAAA_AAAA, -8'sd128);
    wait_drained();

    // Random scans, first with no idling on either side, then with the sender
    // idle, the receiver stalling, and both at once.
    run_phase(0, 0, 80);
    run_phase(66, 0, 80);
    run_phase(0, 66, 80);
    run_phase(23, 23, 80);

    // Back pressure: the receiver holds off for a long stretch while the
    // sender keeps offering, so the output register fills and the block must
    // stall its input until the hold-off ends.
    sender_idle_pct = 0;
    stall_pct = 0;
    phase_items = 0;
    while (phase_items < 60) push_scan();
    hold_on = 1'b1;
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (expected_q.size() != 0) begin
      $error("%0d results still expected at the end", expected_q.size());
      error_count++;
    end
    $display("Covered %0d requests and %0d results (%0d new entries, %0d matches).",
             n_requests, n_results, n_new, n_matched);
    $display("The input was stalled for %0d cycles with a request waiting; %0d mismatches.",
             n_blocked, error_count);
    if (error_count == 0) begin
      $display("tb_rssi_neighbor_table: done, clean");
    end else begin
      $display("tb_rssi_neighbor_table: done, errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out: %0d requests unsent, %0d results outstanding.",
             pending_q.size(), expected_q.size());
    $display("tb_rssi_neighbor_table: done, errors");
    $finish;
  end

endmodule
